### hw/rtl/rso_pkg.sv
`timescale 1ns / 1ps

package rso_pkg;

  localparam int unsigned DIGIT_W    = 8;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned JUMP_W     = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned PAIR_CNT_W = 3;
  localparam int unsigned RADIX_W    = DIGIT_W + 1;
  localparam int unsigned LEN_LIMIT  = WORD_W / DIGIT_W;

  // reset values of the configuration registers
  localparam logic [DIGIT_W-1:0]    SYMBOL_COUNT_RST = 8'd26;
  localparam logic [WORD_W-1:0]     START_DIGITS_RST = 64'd0;
  localparam logic [LEN_W-1:0]      START_LENGTH_RST = 4'd1;
  localparam logic [WORD_W-1:0]     END_DIGITS_RST   = 64'd0;
  localparam logic [LEN_W-1:0]      END_LENGTH_RST   = 4'd8;
  localparam logic [WORD_W-1:0]     RANGE_BOUNDS_RST = 64'd31329;
  localparam logic [PAIR_CNT_W-1:0] PAIR_COUNT_RST   = 3'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_START = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_JUMP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYMBOL_COUNT     = 3'd0,
    CFG_START_DIGITS     = 3'd1,
    CFG_START_LENGTH     = 3'd2,
    CFG_END_DIGITS       = 3'd3,
    CFG_END_LENGTH       = 3'd4,
    CFG_RANGE_BOUNDS     = 3'd5,
    CFG_RANGE_PAIR_COUNT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic                done;
    logic [JUMP_W-1:0]   quot;
    logic [DIGIT_W-1:0]  rem;
  } div_res_t;

endpackage

### hw/rtl/rso_divider.sv
`timescale 1ns / 1ps

module rso_divider (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rso_pkg::JUMP_W-1:0]    dividend_i,
  input  logic [rso_pkg::RADIX_W-1:0]   divisor_i,
  output rso_pkg::div_res_t             res_o
);
  import rso_pkg::*;

  localparam int unsigned CNT_W = $clog2(JUMP_W);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [JUMP_W-1:0]    quo_q, quo_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d;
  logic [RADIX_W-1:0]   div_q, div_d;
  logic [RADIX_W-1:0]   trial;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[JUMP_W-1]};
  assign fits  = (trial >= div_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      quo_d = {quo_q[JUMP_W-2:0], fits};
      rem_d = fits ? DIGIT_W'(trial - div_q) : trial[DIGIT_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(JUMP_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.rem  = rem_q;

endmodule

### hw/rtl/ranged_string_candidate_odometer_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  -------------------------------------------
// in        input      in_valid_i / in_stall_o   cmd_i, jump_value_i
// out       output     out_valid_o / out_stall_i candidate_text_o, candidate_length_o,
//                                                range_done_o
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// Start, step, the unused command and a zero jump go from the accepting edge, which updates the
// digits for start and step, to the load state, which fills the output register once it is free.
// Other jumps run the bit-serial divider once per digit written, for k digits (k up to the current
// length), and then go to the load state.
// No new item is taken until the previous one sits in the output register; a stalled output
// holds the block in its load state. Reset: register defaults, zero digits, length one.

module ranged_string_candidate_odometer_unit #(
  parameter int unsigned MAX_DIGITS      = 8,
  parameter int unsigned MAX_RANGE_PAIRS = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // item input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rso_pkg::CMD_W-1:0]         cmd_i,
  input  logic [rso_pkg::JUMP_W-1:0]        jump_value_i,
  // item output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [rso_pkg::WORD_W-1:0]        candidate_text_o,
  output logic [rso_pkg::LEN_W-1:0]         candidate_length_o,
  output logic                              range_done_o,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rso_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rso_pkg::WORD_W-1:0]        cfg_data_i
);
  import rso_pkg::*;

  // configuration registers
  logic [DIGIT_W-1:0]    sym_cnt_q;
  logic [WORD_W-1:0]     start_dig_q;
  logic [LEN_W-1:0]      start_len_q;
  logic [WORD_W-1:0]     end_dig_q;
  logic [LEN_W-1:0]      end_len_q;
  logic [WORD_W-1:0]     bounds_q;
  logic [PAIR_CNT_W-1:0] pair_cnt_q;

  // odometer state
  state_e                state_q, state_d;
  logic [DIGIT_W-1:0]    dig_q [MAX_DIGITS];
  logic [DIGIT_W-1:0]    dig_d [MAX_DIGITS];
  logic [LEN_W-1:0]      len_q, len_d;
  logic                  done_q, done_d;
  logic [LEN_W-1:0]      pos_q, pos_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [WORD_W-1:0]     text_q, text_d;
  logic [LEN_W-1:0]      olen_q;
  logic                  odone_q;

  // step datapath
  logic [DIGIT_W-1:0]    step_dig [MAX_DIGITS];
  logic [LEN_W-1:0]      step_len;
  logic                  step_done;
  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    inc;
  logic                  carry, all_zero, match, zmatch;
  logic [LEN_W-1:0]      elen, slen;
  logic [PAIR_CNT_W-1:0] pairs_eff;

  // control
  logic                  in_acc, cfg_wr;
  logic                  div_start, emit_load, div_last;
  logic [JUMP_W-1:0]     div_dividend;
  div_res_t              div_res;
  cmd_e                  cmd;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) r = LEN_W'(1);
    else if (v > LEN_W'(MAX_DIGITS)) r = LEN_W'(MAX_DIGITS);
    return r;
  endfunction

  // walk the character ranges in order; a digit past all of them maps to zero
  function automatic logic [DIGIT_W-1:0] char_for(input logic [DIGIT_W-1:0] pos_in);
    logic [RADIX_W-1:0] pos, size;
    logic [DIGIT_W-1:0] lo, hi, ch;
    logic               found;
    pos   = {1'b0, pos_in};
    ch    = '0;
    found = 1'b0;
    for (int k = 0; k < MAX_RANGE_PAIRS; k++) begin
      lo = bounds_q[2*DIGIT_W*k +: DIGIT_W];
      hi = bounds_q[2*DIGIT_W*k + DIGIT_W +: DIGIT_W];
      if (!found && (PAIR_CNT_W'(k) < pairs_eff) && (lo <= hi)) begin
        size = {1'b0, hi} - {1'b0, lo} + RADIX_W'(1);
        if (pos < size) begin
          ch    = lo + pos[DIGIT_W-1:0];
          found = 1'b1;
        end else begin
          pos = pos - size;
        end
      end
    end
    return ch;
  endfunction

  assign cmd         = cmd_e'(cmd_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  // a symbol count of zero stands for a full byte alphabet
  assign radix     = (sym_cnt_q == '0) ? RADIX_W'(1 << DIGIT_W) : {1'b0, sym_cnt_q};
  assign elen      = clamp_len(end_len_q);
  assign slen      = clamp_len(start_len_q);
  assign pairs_eff = (pair_cnt_q > PAIR_CNT_W'(MAX_RANGE_PAIRS)) ?
                     PAIR_CNT_W'(MAX_RANGE_PAIRS) : pair_cnt_q;

  // increment the last digit with carry toward digit 0, then grow or finish
  always_comb begin
    carry     = 1'b1;
    all_zero  = 1'b1;
    match     = 1'b1;
    zmatch    = 1'b1;
    inc       = '0;
    step_dig  = dig_q;
    for (int i = MAX_DIGITS - 1; i >= 0; i--) begin
      if ((LEN_W'(i) < len_q) && carry) begin
        inc = {1'b0, dig_q[i]} + RADIX_W'(1);
        if (inc >= radix) begin
          step_dig[i] = '0;
        end else begin
          step_dig[i] = inc[DIGIT_W-1:0];
          carry       = 1'b0;
        end
      end
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (LEN_W'(i) < len_q) begin
        if (step_dig[i] != '0) all_zero = 1'b0;
        if (step_dig[i] != end_dig_q[DIGIT_W*i +: DIGIT_W]) match = 1'b0;
      end
    end
    step_len  = len_q;
    step_done = done_q;
    if (all_zero) begin
      if (len_q < elen) begin
        step_len = len_q + LEN_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
          if (LEN_W'(i) == len_q) step_dig[i] = '0;
        end
      end else begin
        step_done = 1'b1;
      end
    end
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if ((LEN_W'(i) < step_len) && (end_dig_q[DIGIT_W*i +: DIGIT_W] != '0)) zmatch = 1'b0;
    end
    if ((step_len == elen) && match && !all_zero) step_done = 1'b1;
    if ((step_len == elen) && all_zero && zmatch) step_done = 1'b1;
  end

  // the divider has produced the last digit of a jump
  assign div_last = (div_res.quot == '0) || (pos_q == LEN_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if ((cmd == CMD_JUMP) && (jump_value_i != '0)) state_d = ST_DIV;
          else state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_res.done && div_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o   = 1'b1;
    div_start    = 1'b0;
    div_dividend = div_res.quot;
    emit_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        div_dividend = jump_value_i;
        div_start    = in_acc && (cmd == CMD_JUMP) && (jump_value_i != '0);
      end
      ST_DIV: begin
        div_start = div_res.done && !div_last;
      end
      ST_EMIT: begin
        emit_load = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  // digit store, length and done flag
  always_comb begin
    dig_d  = dig_q;
    len_d  = len_q;
    done_d = done_q;
    pos_d  = pos_q;
    if ((state_q == ST_IDLE) && in_acc) begin
      case (cmd)
        CMD_START: begin
          len_d  = slen;
          done_d = 1'b0;
          for (int i = 0; i < MAX_DIGITS; i++) begin
            dig_d[i] = (LEN_W'(i) < slen) ? start_dig_q[DIGIT_W*i +: DIGIT_W] : '0;
          end
        end
        CMD_STEP: begin
          dig_d  = step_dig;
          len_d  = step_len;
          done_d = step_done;
        end
        CMD_JUMP: pos_d = len_q;
        default: ;
      endcase
    end
    // write the remainder into the digit below the write pointer
    if ((state_q == ST_DIV) && div_res.done) begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
        if (LEN_W'(i) == pos_q - LEN_W'(1)) dig_d[i] = div_res.rem;
      end
      pos_d = pos_q - LEN_W'(1);
    end
  end

  // map digits to characters; bytes past the length stay zero
  always_comb begin
    text_d = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (LEN_W'(i) < len_q) text_d[DIGIT_W*i +: DIGIT_W] = char_for(dig_q[i]);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  rso_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (radix),
    .res_o      (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_cnt_q   <= SYMBOL_COUNT_RST;
      start_dig_q <= START_DIGITS_RST;
      start_len_q <= START_LENGTH_RST;
      end_dig_q   <= END_DIGITS_RST;
      end_len_q   <= END_LENGTH_RST;
      bounds_q    <= RANGE_BOUNDS_RST;
      pair_cnt_q  <= PAIR_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SYMBOL_COUNT:     sym_cnt_q   <= cfg_data_i[DIGIT_W-1:0];
        CFG_START_DIGITS:     start_dig_q <= cfg_data_i;
        CFG_START_LENGTH:     start_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_END_DIGITS:       end_dig_q   <= cfg_data_i;
        CFG_END_LENGTH:       end_len_q   <= cfg_data_i[LEN_W-1:0];
        CFG_RANGE_BOUNDS:     bounds_q    <= cfg_data_i;
        CFG_RANGE_PAIR_COUNT: pair_cnt_q  <= cfg_data_i[PAIR_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(1);
      done_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_DIGITS; i++) dig_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      done_q      <= done_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      dig_q       <= dig_d;
    end
  end

  // hold the result item until taken
  always_ff @(posedge clk_i) begin
    if (emit_load) begin
      text_q  <= text_d;
      olen_q  <= len_q;
      odone_q <= done_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign candidate_text_o   = text_q;
  assign candidate_length_o = olen_q;
  assign range_done_o       = odone_q;

endmodule

### hw/rtl/rso_checker.sv
`timescale 1ns / 1ps

module rso_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic [rso_pkg::WORD_W-1:0]   candidate_text_o,
  input  logic [rso_pkg::LEN_W-1:0]    candidate_length_o,
  input  logic                         range_done_o
);
  import rso_pkg::*;

  logic [WORD_W-1:0] tail_mask;

  always_comb begin
    tail_mask = '0;
    for (int i = 0; i < LEN_LIMIT; i++) begin
      if (LEN_W'(i) >= candidate_length_o) tail_mask[DIGIT_W*i +: DIGIT_W] = '1;
    end
  end

  // a stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(candidate_text_o)
      && $stable(candidate_length_o) && $stable(range_done_o))
    else $error("result item changed under stall");

  // one item at a time: after acceptance the input stalls
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken on back-to-back cycles");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (candidate_length_o != '0) && (candidate_length_o <= LEN_W'(LEN_LIMIT)))
    else $error("candidate length out of range");

  a_tail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((candidate_text_o & tail_mask) == '0))
    else $error("characters past the candidate length");

endmodule

bind ranged_string_candidate_odometer_unit rso_checker u_rso_checker (.*);
